// ===== design/pli_pkg.sv =====
// Shared constants and types for the piecewise linear interpolator.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package pli_pkg;

	typedef logic [1:0] status_t;
	typedef logic [1:0] cfg_index_t;

	// Configuration register indexes
	localparam cfg_index_t REG_POINT_COUNT = 2'd0;
	localparam cfg_index_t REG_BOUND_TOL   = 2'd1;

	// Commands carried on the input channel
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Result status codes
	localparam status_t STATUS_OK     = 2'd0;
	localparam status_t STATUS_BOUNDS = 2'd1;
	localparam status_t STATUS_DUP_X  = 2'd2;

	// Register reset values
	localparam logic [4:0]  POINT_COUNT_RST = 5'd2;
	localparam logic [30:0] BOUND_TOL_RST   = 31'd655;

endpackage

`default_nettype wire

// ===== design/pli_ram.sv =====
// Generic simple RAM: one write port and two read ports with registered read data.
// No dependencies.
`default_nettype none

module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// ===== design/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator over a breakpoint table held in two RAMs.
// Depends on pli_pkg and pli_ram.
//
// Usage: the input channel (in_valid/in_ready) carries either a breakpoint
// write (command = write, point_index, point_x, point_y) or a query
// (command = query, query_x). A write gives no result.
// A query gives one beat on the output channel (interp_value, status).
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
// the point count and the bound tolerance; it is always ready and must only
// be used while no query is in flight.
// A query runs a repeated-x scan over every pair of breakpoints in use, through
// the two read ports of the x table, then a walk over the segments; a match with
// no error then goes through a shared 32x33 multiplier and a radix-2 divider.
// One query is in work at a time. The result sits in an output register; the
// block takes the next item while it waits, and a finished query holds until
// that register is free. Reset clears the control state and the registers to a
// point count of 2 and a tolerance of 655; tables are undefined until written.
`default_nettype none

module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               command,
	input  wire logic [3:0]         point_index,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] query_x,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      interp_value,
	output logic [1:0]              status,
	// configuration channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DUP  = 4'd1;
	localparam logic [3:0] ST_SEG  = 4'd2;
	localparam logic [3:0] ST_PREP = 4'd3;
	localparam logic [3:0] ST_MUL0 = 4'd4;
	localparam logic [3:0] ST_MUL1 = 4'd5;
	localparam logic [3:0] ST_SUM  = 4'd6;
	localparam logic [3:0] ST_ABS  = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0]  state_q;
	logic [4:0]  point_count_q;
	logic [30:0] bound_tol_q;

	logic [CW-1:0] n_q, i_q, j_q, n_used, n_m1, n_m2;
	logic          issue_q, pend_s1, first_s1, last_s1;
	logic          dup_q, found_q;
	logic signed [31:0] u_q, xfirst_q, xlast_q;
	logic signed [31:0] sel_x0_q, sel_x1_q, sel_y0_q, sel_y1_q;
	logic [31:0]   w0_q, w1_q, d_q;
	logic [63:0]   p0_q, p1_q;
	logic          neg_q;
	logic [31:0]   rem_q, quo_q;
	logic [4:0]    cnt_q;
	logic signed [31:0] res_value_q;
	pli_pkg::status_t   res_status_q;
	logic signed [31:0] out_value_q;
	pli_pkg::status_t   out_status_q;
	logic               out_valid_q;

	logic          in_acc, wr_acc, qry_acc;
	logic [31:0]   widx;
	logic          ram_we;
	logic [IW-1:0] waddr, raddr_a, raddr_b;
	logic [31:0]   rx_a, rx_b, ry_a, ry_b;
	logic signed [31:0] x0, x1, y0, y1;
	logic          seg_match;
	logic signed [32:0] lo_diff, hi_diff, tol_pos, tol_neg;
	logic          out_of_bounds;
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [64:0] prod;
	logic [63:0]   mag;
	logic [32:0]   shifted, trial;
	logic          ge;
	logic [31:0]   quo_sat;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign wr_acc    = in_acc && (command == pli_pkg::CMD_WRITE);
	assign qry_acc   = in_acc && (command == pli_pkg::CMD_QUERY);

	// Clamp the point count to 2..MAX_POINTS
	always_comb begin
		if (point_count_q < 5'd2) begin
			n_used = CW'(2);
		end else if (32'(point_count_q) > 32'(MAX_POINTS)) begin
			n_used = CW'(MAX_POINTS);
		end else begin
			n_used = CW'(point_count_q);
		end
	end

	assign n_m1 = n_q - CW'(1);
	assign n_m2 = n_q - CW'(2);

	// Writes beyond the table are dropped
	assign widx   = 32'(point_index);
	assign waddr  = widx[IW-1:0];
	assign ram_we = wr_acc && (widx < 32'(MAX_POINTS));

	assign raddr_a = i_q[IW-1:0];
	assign raddr_b = j_q[IW-1:0];

	pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (waddr),
		.wdata   (point_x),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rx_a),
		.rdata_b (rx_b)
	);

	pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_y_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (waddr),
		.wdata   (point_y),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (ry_a),
		.rdata_b (ry_b)
	);

	assign x0 = $signed(rx_a);
	assign x1 = $signed(rx_b);
	assign y0 = $signed(ry_a);
	assign y1 = $signed(ry_b);
	assign seg_match = (x0 <= u_q) && (u_q <= x1) && (x0 < x1);

	assign lo_diff = $signed({u_q[31], u_q}) - $signed({xfirst_q[31], xfirst_q});
	assign hi_diff = $signed({u_q[31], u_q}) - $signed({xlast_q[31], xlast_q});
	assign tol_pos = $signed({2'b00, bound_tol_q});
	assign tol_neg = -tol_pos;
	assign out_of_bounds = (lo_diff < tol_neg) || (hi_diff > tol_pos);

	// One shared multiplier: signed ordinate times unsigned weight
	assign mul_a = (state_q == ST_MUL0) ? sel_y0_q : sel_y1_q;
	assign mul_b = $signed({1'b0, (state_q == ST_MUL0) ? w0_q : w1_q});
	assign prod  = 65'(mul_a) * 65'(mul_b);

	assign mag = p0_q[63] ? (64'd0 - p0_q) : p0_q;

	// One quotient bit a cycle; remainder stays below the divisor
	assign shifted = {rem_q, quo_q[31]};
	assign trial   = shifted - {1'b0, d_q};
	assign ge      = (shifted >= {1'b0, d_q});

	always_comb begin
		if (neg_q) begin
			quo_sat = (quo_q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo_q);
		end else begin
			quo_sat = (quo_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_q;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= pli_pkg::POINT_COUNT_RST;
			bound_tol_q   <= pli_pkg::BOUND_TOL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pli_pkg::REG_POINT_COUNT: point_count_q <= cfg_data[4:0];
				pli_pkg::REG_BOUND_TOL:   bound_tol_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (qry_acc) begin
						state_q <= ST_DUP;
						issue_q <= 1'b1;
					end
				end
				ST_DUP: begin
					if (issue_q) begin
						pend_s1 <= 1'b1;
						if (j_q == n_m1 && i_q == n_m2) begin
							issue_q <= 1'b0;
						end
					end else if (!pend_s1) begin
						state_q <= ST_SEG;
						issue_q <= 1'b1;
					end
				end
				ST_SEG: begin
					if (issue_q) begin
						pend_s1 <= 1'b1;
						if (i_q == n_m2) begin
							issue_q <= 1'b0;
						end
					end else if (!pend_s1) begin
						if (dup_q || out_of_bounds || !found_q) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == 5'd31) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN:  state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				i_q     <= CW'(0);
				j_q     <= CW'(1);
				u_q     <= query_x;
				n_q     <= n_used;
				dup_q   <= 1'b0;
				found_q <= 1'b0;
			end
			ST_DUP: begin
				if (issue_q) begin
					if (j_q == n_m1) begin
						if (i_q != n_m2) begin
							i_q <= i_q + CW'(1);
							j_q <= i_q + CW'(2);
						end
					end else begin
						j_q <= j_q + CW'(1);
					end
				end else if (!pend_s1) begin
					i_q <= CW'(0);
					j_q <= CW'(1);
				end
				if (pend_s1 && rx_a == rx_b) begin
					dup_q <= 1'b1;
				end
			end
			ST_SEG: begin
				if (issue_q) begin
					first_s1 <= (i_q == CW'(0));
					last_s1  <= (i_q == n_m2);
					if (i_q != n_m2) begin
						i_q <= i_q + CW'(1);
						j_q <= j_q + CW'(1);
					end
				end
				if (pend_s1) begin
					if (first_s1) begin
						xfirst_q <= x0;
					end
					if (last_s1) begin
						xlast_q <= x1;
					end
					// later segments overwrite earlier matches
					if (seg_match) begin
						found_q  <= 1'b1;
						sel_x0_q <= x0;
						sel_x1_q <= x1;
						sel_y0_q <= y0;
						sel_y1_q <= y1;
					end
				end
				if (!issue_q && !pend_s1) begin
					res_value_q <= '0;
					if (dup_q) begin
						res_status_q <= pli_pkg::STATUS_DUP_X;
					end else if (out_of_bounds) begin
						res_status_q <= pli_pkg::STATUS_BOUNDS;
					end else begin
						res_status_q <= pli_pkg::STATUS_OK;
					end
				end
			end
			ST_PREP: begin
				w0_q <= 32'(sel_x1_q - u_q);
				w1_q <= 32'(u_q - sel_x0_q);
				d_q  <= 32'(sel_x1_q - sel_x0_q);
			end
			ST_MUL0: p0_q <= prod[63:0];
			ST_MUL1: p1_q <= prod[63:0];
			ST_SUM:  p0_q <= p0_q + p1_q;
			ST_ABS: begin
				neg_q <= p0_q[63];
				rem_q <= mag[63:32];
				quo_q <= mag[31:0];
				cnt_q <= 5'd0;
			end
			ST_DIV: begin
				rem_q <= ge ? trial[31:0] : shifted[31:0];
				quo_q <= {quo_q[30:0], ge};
				cnt_q <= cnt_q + 5'd1;
			end
			ST_FIN: begin
				res_value_q  <= $signed(quo_sat);
				res_status_q <= pli_pkg::STATUS_OK;
			end
			default: ;
		endcase
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign interp_value = out_value_q;
	assign status       = out_status_q;

endmodule

`default_nettype wire

// ===== design/pli_checker.sv =====
// Port-level checker for the piecewise linear interpolator, bound to the top level.
// Depends on pli_pkg.
`default_nettype none

module pli_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               command,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] interp_value,
	input wire logic [1:0]         status
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(interp_value) && $stable(status))
		else $error("result beat changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == pli_pkg::STATUS_OK || status == pli_pkg::STATUS_BOUNDS ||
			status == pli_pkg::STATUS_DUP_X))
		else $error("status code out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pli_pkg::STATUS_OK |-> interp_value == 32'sd0)
		else $error("non-zero value on error status");

	// A query keeps the block busy, so the input is not ready while it is in work
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == pli_pkg::CMD_QUERY |=> !in_ready)
		else $error("input taken right after a query beat");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for piecewise_linear_interpolator: a directed table, then random phases.
// Depends on pli_pkg and the design; a model here predicts query results not set in the plan.
module tb;

	localparam int                  TABLE_DEPTH     = 16;
	localparam int                  PHASES          = 8;
	localparam int                  ITEMS_PER_PHASE = 190;
	localparam int                  QUIET_CYCLES    = 8;
	localparam int                  TAIL_CYCLES     = 200;
	localparam int unsigned         RUN_LIMIT       = 60_000_000;
	localparam longint              X_MIN           = -64'sd2147483648;
	localparam longint              X_SPAN          = 64'sd4294967295;
	localparam pli_pkg::cfg_index_t REG_SPARE_LO    = 2'd2;
	localparam pli_pkg::cfg_index_t REG_SPARE_HI    = 2'd3;

	typedef struct packed {
		logic signed [31:0] value;
		pli_pkg::status_t   st;
	} answer_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic                cmd;
		logic [3:0]          idx;
		logic signed [31:0]  px;
		logic signed [31:0]  py;
		logic signed [31:0]  qx;
		pli_pkg::cfg_index_t reg_sel;
		logic [31:0]         data;
		logic                typed;
		answer_t             want;
	} step_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               command;
	logic [3:0]         point_index;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] query_x;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] interp_value;
	logic [1:0]         status;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	// breakpoint tables and registers as the block should hold them
	logic signed [31:0] bp_x [TABLE_DEPTH];
	logic signed [31:0] bp_y [TABLE_DEPTH];
	logic [4:0]         cnt_reg;
	logic [30:0]        tol_reg;

	answer_t   answers_due [$];
	step_row_t plan [$];
	int        faults;
	int        items_sent;
	bit        in_calm;
	bit        out_calm;

	piecewise_linear_interpolator #(
		.MAX_POINTS(TABLE_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.point_index (point_index),
		.point_x     (point_x),
		.point_y     (point_y),
		.query_x     (query_x),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.interp_value(interp_value),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	function automatic int points_in_use();
		if (cnt_reg < 2)
			return 2;
		if (cnt_reg > TABLE_DEPTH)
			return TABLE_DEPTH;
		return int'(cnt_reg);
	endfunction

	function automatic answer_t interpolate(logic signed [31:0] u);
		answer_t a;
		int      n, i, j;
		longint  lu, tol, lo, hi, y0, y1, num, q;
		a.value = '0;
		a.st = pli_pkg::STATUS_OK;
		n = points_in_use();
		lu = longint'(u);
		tol = {33'b0, tol_reg};
		for (i = 0; i < n - 1 && a.st == pli_pkg::STATUS_OK; i++)
			for (j = i + 1; j < n; j++)
				if (bp_x[i] == bp_x[j])
					a.st = pli_pkg::STATUS_DUP_X;
		lo = longint'(bp_x[0]);
		hi = longint'(bp_x[n - 1]);
		if (a.st == pli_pkg::STATUS_OK && (lu - lo < -tol || lu - hi > tol))
			a.st = pli_pkg::STATUS_BOUNDS;
		if (a.st != pli_pkg::STATUS_OK)
			return a;
		// the last segment holding u wins; descending segments never hold it
		for (i = 0; i < n - 1; i++) begin
			lo = longint'(bp_x[i]);
			hi = longint'(bp_x[i + 1]);
			if (lo <= lu && lu <= hi && lo < hi) begin
				y0 = longint'(bp_y[i]);
				y1 = longint'(bp_y[i + 1]);
				num = y0 * (hi - lu) + y1 * (lu - lo);
				q = num / (hi - lo);
				if (q > 64'sd2147483647)
					q = 64'sd2147483647;
				if (q < X_MIN)
					q = X_MIN;
				a.value = q[31:0];
			end
		end
		return a;
	endfunction

	function automatic longint rand_upto(longint span);
		bit [63:0] r;
		r = {$urandom, $urandom};
		return longint'(r % (span + 1));
	endfunction

	function automatic logic signed [31:0] pick_query_x();
		int     n;
		longint lo, hi, tol, v;
		n = points_in_use();
		lo = longint'(bp_x[0]);
		hi = longint'(bp_x[n - 1]);
		tol = {33'b0, tol_reg};
		case ($urandom_range(0, 9)) inside
			[0:4]: begin
				v = (hi > lo) ? lo + rand_upto(hi - lo) : X_MIN + rand_upto(X_SPAN);
			end
			5: v = longint'(bp_x[$urandom_range(0, n - 1)]);
			6: begin
				v = longint'(bp_x[$urandom_range(0, n - 1)]);
				v = v + ($urandom_range(0, 1) ? 1 : -1);
			end
			7: v = lo - tol - int'($urandom_range(0, 1));
			8: v = hi + tol + int'($urandom_range(0, 1));
			default: v = X_MIN + rand_upto(X_SPAN);
		endcase
		if (v < X_MIN || v > X_MIN + X_SPAN)
			v = X_MIN + rand_upto(X_SPAN);
		return v[31:0];
	endfunction

	function automatic step_row_t row_write(logic [3:0] idx, logic signed [31:0] x,
			logic signed [31:0] y);
		step_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.cmd = pli_pkg::CMD_WRITE;
		r.idx = idx;
		r.px = x;
		r.py = y;
		return r;
	endfunction

	function automatic step_row_t row_query(logic signed [31:0] u);
		step_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.cmd = pli_pkg::CMD_QUERY;
		r.qx = u;
		return r;
	endfunction

	function automatic step_row_t row_query_is(logic signed [31:0] u, logic signed [31:0] v,
			pli_pkg::status_t st);
		step_row_t r;
		r = row_query(u);
		r.typed = 1'b1;
		r.want.value = v;
		r.want.st = st;
		return r;
	endfunction

	function automatic step_row_t row_cfg(pli_pkg::cfg_index_t sel, logic [31:0] data);
		step_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.reg_sel = sel;
		r.data = data;
		return r;
	endfunction

	// Enter and leave on a falling edge; valid stays high on exit so that a
	// back-to-back beat keeps it up without a glitch.
	task automatic offer_item(input logic cmd, input logic [3:0] idx,
			input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] qx, input logic typed, input answer_t want);
		int gap;
		if ($urandom_range(0, 39) == 0)
			in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		point_index <= idx;
		point_x <= px;
		point_y <= py;
		query_x <= qx;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		items_sent++;
		if (cmd == pli_pkg::CMD_WRITE) begin
			bp_x[idx] = px;
			bp_y[idx] = py;
		end else begin
			answers_due.push_back(typed ? want : interpolate(qx));
		end
		@(negedge clk);
	endtask

	task automatic drain_answers();
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(negedge clk);
		// let a trailing breakpoint write land
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input pli_pkg::cfg_index_t sel, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		if (sel == pli_pkg::REG_POINT_COUNT)
			cnt_reg = data[4:0];
		else if (sel == pli_pkg::REG_BOUND_TOL)
			tol_reg = data[30:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Ascending x over every entry in use, so that queries get past the repeated-x check.
	task automatic load_breakpoints();
		int                 n, i;
		longint             step_max, x;
		logic signed [31:0] y;
		bit                 wide_y;
		n = points_in_use();
		case ($urandom_range(0, 3))
			0: step_max = 16;
			1: step_max = 64'sd4096;
			2: step_max = 64'sd1048576;
			default: step_max = 64'sd134217728;
		endcase
		wide_y = ($urandom_range(0, 1) == 1);
		x = X_MIN + rand_upto(X_SPAN - (n - 1) * step_max);
		for (i = 0; i < n; i++) begin
			y = wide_y ? $urandom : $urandom_range(0, 2097151) - 1048576;
			offer_item(pli_pkg::CMD_WRITE, i[3:0], x[31:0], y, $urandom, 1'b0, '0);
			x = x + 1 + rand_upto(step_max - 1);
		end
	endtask

	initial begin
		answer_t want;
		int      stall;
		out_ready = 1'b0;
		out_calm = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				out_calm = !out_calm;
			stall = out_calm ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1)
				@(posedge clk);
			if (answers_due.size() == 0) begin
				faults++;
				$display("%0t: result with none expected: interp_value %h status %0d",
					$time, interp_value, status);
			end else begin
				want = answers_due.pop_front();
				if (interp_value !== want.value) begin
					faults++;
					$display("%0t: interp_value expected %h got %h",
						$time, want.value, interp_value);
				end
				if (status !== want.st) begin
					faults++;
					$display("%0t: status expected %0d got %0d", $time, want.st, status);
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		int          ph, pick, n, k, target;
		logic [4:0]  cnt;
		logic [30:0] tol;
		in_valid = 1'b0;
		command = pli_pkg::CMD_WRITE;
		point_index = '0;
		point_x = '0;
		point_y = '0;
		query_x = '0;
		cfg_valid = 1'b0;
		cfg_index = pli_pkg::REG_POINT_COUNT;
		cfg_data = '0;
		arst_n = 1'b0;
		cnt_reg = pli_pkg::POINT_COUNT_RST;
		tol_reg = pli_pkg::BOUND_TOL_RST;
		faults = 0;
		items_sent = 0;
		in_calm = 1'b0;

		// two points in use after reset, tolerance 655
		plan.push_back(row_write(4'd0, 32'h0000_0000, 32'h0000_0000));
		plan.push_back(row_write(4'd1, 32'h0001_0000, 32'h0002_0000));
		plan.push_back(row_query_is(32'h0000_8000, 32'h0001_0000, pli_pkg::STATUS_OK));
		plan.push_back(row_query_is(32'h0001_0000, 32'h0002_0000, pli_pkg::STATUS_OK));
		// inside the tolerance but past the last point: no segment, zero
		plan.push_back(row_query_is(32'h0001_028F, 32'h0, pli_pkg::STATUS_OK));
		plan.push_back(row_query_is(32'h0001_0290, 32'h0, pli_pkg::STATUS_BOUNDS));
		plan.push_back(row_query_is(-32'sd655, 32'h0, pli_pkg::STATUS_OK));
		plan.push_back(row_query_is(-32'sd656, 32'h0, pli_pkg::STATUS_BOUNDS));
		plan.push_back(row_query_is(32'h7FFF_FFFF, 32'h0, pli_pkg::STATUS_BOUNDS));
		plan.push_back(row_query_is(32'h8000_0000, 32'h0, pli_pkg::STATUS_BOUNDS));
		// counts below two clamp up to two
		plan.push_back(row_cfg(pli_pkg::REG_POINT_COUNT, 32'hFFFF_FFE0));
		plan.push_back(row_query(32'h0000_C000));
		plan.push_back(row_cfg(pli_pkg::REG_POINT_COUNT, 32'h0000_0001));
		// repeated x outranks the bounds check
		plan.push_back(row_write(4'd1, 32'h0000_0000, 32'h0000_0005));
		plan.push_back(row_query_is(32'h7FFF_FFFF, 32'h0, pli_pkg::STATUS_DUP_X));
		plan.push_back(row_write(4'd0, 32'h8000_0000, 32'h8000_0000));
		plan.push_back(row_write(4'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		plan.push_back(row_query_is(32'h8000_0000, 32'h8000_0000, pli_pkg::STATUS_OK));
		plan.push_back(row_query_is(32'h7FFF_FFFF, 32'h7FFF_FFFF, pli_pkg::STATUS_OK));
		plan.push_back(row_query(32'h1234_5678));
		// widest tolerance, then a descending segment that never matches
		plan.push_back(row_cfg(pli_pkg::REG_BOUND_TOL, 32'hFFFF_FFFF));
		plan.push_back(row_write(4'd0, 32'h0001_0000, 32'h0000_1234));
		plan.push_back(row_write(4'd1, 32'h0000_0000, 32'h0000_5678));
		plan.push_back(row_query_is(32'h0000_8000, 32'h0, pli_pkg::STATUS_OK));
		plan.push_back(row_cfg(REG_SPARE_HI, 32'hFFFF_FFFF));
		plan.push_back(row_query_is(32'h7FFF_FFFF, 32'h0, pli_pkg::STATUS_OK));
		plan.push_back(row_cfg(REG_SPARE_LO, 32'h0000_0000));
		plan.push_back(row_cfg(pli_pkg::REG_BOUND_TOL, 32'h0000_0000));
		plan.push_back(row_write(4'd1, 32'h0002_0000, 32'h0003_0000));
		plan.push_back(row_query_is(32'h0000_FFFF, 32'h0, pli_pkg::STATUS_BOUNDS));
		plan.push_back(row_query_is(32'h0002_0001, 32'h0, pli_pkg::STATUS_BOUNDS));
		plan.push_back(row_query(32'h0001_8000));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain_answers();
				write_reg(plan[i].reg_sel, plan[i].data);
			end else begin
				offer_item(plan[i].cmd, plan[i].idx, plan[i].px, plan[i].py, plan[i].qx,
					plan[i].typed, plan[i].want);
			end
		end

		// phase 0 uses all sixteen entries, so every entry is written before
		// any later phase reads it
		for (ph = 0; ph < PHASES; ph++) begin
			drain_answers();
			case (ph)
				0: cnt = 5'd16;
				1: cnt = 5'd31;
				2: cnt = 5'($urandom_range(3, 6));
				3: cnt = 5'd0;
				4: cnt = 5'($urandom_range(17, 30));
				5: cnt = 5'($urandom_range(2, 16));
				6: cnt = 5'd1;
				default: cnt = 5'($urandom_range(3, 8));
			endcase
			case (ph)
				0: tol = pli_pkg::BOUND_TOL_RST;
				1: tol = '0;
				2: tol = 31'h7FFF_FFFF;
				3: tol = 31'($urandom_range(0, 65535));
				4: tol = 31'($urandom);
				5: tol = 31'd1;
				6: tol = 31'($urandom_range(0, 2000));
				default: tol = 31'($urandom_range(0, 1048576));
			endcase
			write_reg(pli_pkg::REG_POINT_COUNT, ($urandom & 32'hFFFF_FFE0) | {27'b0, cnt});
			write_reg(pli_pkg::REG_BOUND_TOL, ($urandom & 32'h8000_0000) | {1'b0, tol});
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
			load_breakpoints();
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target) begin
				pick = $urandom_range(0, 99);
				n = points_in_use();
				if (pick < 12) begin
					load_breakpoints();
				end else if (pick < 93) begin
					repeat ($urandom_range(1, 6))
						offer_item(pli_pkg::CMD_QUERY, 4'($urandom), $urandom, $urandom,
							pick_query_x(), 1'b0, '0);
				end else if (pick < 96) begin
					// stray write anywhere in the table
					offer_item(pli_pkg::CMD_WRITE, 4'($urandom), $urandom, $urandom, $urandom,
						1'b0, '0);
				end else if (pick < 98) begin
					// copy an x in use onto an entry in use
					k = $urandom_range(0, n - 1);
					offer_item(pli_pkg::CMD_WRITE, 4'($urandom_range(0, n - 1)), bp_x[k],
						$urandom, $urandom, 1'b0, '0);
				end else begin
					drain_answers();
				end
			end
		end

		drain_answers();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (faults == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
